### hdl/typed_address_interval_table_assert.svh
// assertion macros for the typed address interval table checks
`ifndef TYPED_ADDRESS_INTERVAL_TABLE_ASSERT_SVH
`define TYPED_ADDRESS_INTERVAL_TABLE_ASSERT_SVH

// checked only out of reset
`define TAIT_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TAIT_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tait_pkg.sv
// shared types and codes of the typed address interval table
package tait_pkg;

	localparam logic [1:0] ACT_MARK   = 2'd0;
	localparam logic [1:0] ACT_REMARK = 2'd1;
	localparam logic [1:0] ACT_FIND   = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [1:0] KIND_UNEXPLORED = 2'd0;
	localparam logic [1:0] KIND_INVALID    = 2'd3;

	typedef enum logic [2:0] {
		OP_HOLD      = 3'd0,
		OP_SCAN      = 3'd1,
		OP_TRIM      = 3'd2,
		OP_SWAP_EVEN = 3'd3,
		OP_SWAP_ODD  = 3'd4,
		OP_INSERT    = 3'd5,
		OP_REMARK    = 3'd6
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_cmd_t;

	typedef struct packed {
		logic ahead;
		logic hit;
		logic dead;
		logic split;
		logic took_new;
	} cell_stat_t;

endpackage

### hdl/tait_cell.sv
// one table slot: holds an interval and moves it to or from its neighbors
module tait_cell #(
	parameter int IDX = 0,
	parameter int AB  = 64,
	parameter int FB  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tait_pkg::cell_cmd_t  cmd,
	input  logic [AB-1:0]        s,
	input  logic [AB-1:0]        e,
	input  logic [AB-1:0]        ins_first,
	input  logic [AB-1:0]        ins_last,
	input  logic [1:0]           ins_kind,
	input  logic [FB-1:0]        ins_flags,
	input  logic                 prev_valid,
	input  logic                 prev_ahead,
	input  logic [AB-1:0]        prev_first,
	input  logic [AB-1:0]        prev_last,
	input  logic [1:0]           prev_kind,
	input  logic [FB-1:0]        prev_flags,
	input  logic                 next_valid,
	input  logic [AB-1:0]        next_first,
	input  logic [AB-1:0]        next_last,
	input  logic [1:0]           next_kind,
	input  logic [FB-1:0]        next_flags,
	output logic                 valid,
	output logic [AB-1:0]        first,
	output logic [AB-1:0]        last,
	output logic [1:0]           kind,
	output logic [FB-1:0]        flags,
	output tait_pkg::cell_stat_t stat
);

	logic          valid_q, dead_q, lefte_q, righte_q, split_q;
	logic [AB-1:0] first_q, last_q;
	logic [1:0]    kind_q;
	logic [FB-1:0] flags_q;

	logic          valid_d, dead_d, lefte_d, righte_d, split_d;
	logic [AB-1:0] first_d, last_d;
	logic [1:0]    kind_d;
	logic [FB-1:0] flags_d;

	logic ov, le, re, ahead, hit, is_lower;

	always_comb begin
		ov       = valid_q & (last_q >= s) & (first_q <= e);
		le       = ov & (first_q < s);
		re       = ov & (last_q > e);
		ahead    = valid_q & (last_q < ins_first);
		hit      = valid_q & (first_q <= s) & (s <= last_q);
		is_lower = (cmd.op == tait_pkg::OP_SWAP_EVEN) == ((IDX % 2) == 0);

		stat.ahead    = ahead;
		stat.hit      = hit;
		stat.dead     = dead_q;
		stat.split    = split_q;
		stat.took_new = ~ahead & prev_ahead;

		valid_d  = valid_q;
		first_d  = first_q;
		last_d   = last_q;
		kind_d   = kind_q;
		flags_d  = flags_q;
		dead_d   = dead_q;
		lefte_d  = lefte_q;
		righte_d = righte_q;
		split_d  = split_q;

		unique case (cmd.op) inside
			tait_pkg::OP_HOLD: begin
			end
			tait_pkg::OP_SCAN: begin
				dead_d   = ov & ~le & ~re;
				lefte_d  = le;
				righte_d = re;
				split_d  = le & re;
			end
			tait_pkg::OP_TRIM: begin
				if (dead_q) valid_d = 1'b0;
				// a block holding both edges keeps its left part here
				if (lefte_q) begin
					last_d = s - AB'(1);
					kind_d = tait_pkg::KIND_UNEXPLORED;
				end else if (righte_q) begin
					first_d = e + AB'(1);
					kind_d  = tait_pkg::KIND_UNEXPLORED;
				end
				dead_d   = 1'b0;
				lefte_d  = 1'b0;
				righte_d = 1'b0;
				split_d  = 1'b0;
			end
			tait_pkg::OP_SWAP_EVEN, tait_pkg::OP_SWAP_ODD: begin
				// odd-even transposition moves holes to the top, order kept
				if (is_lower) begin
					if (!valid_q && next_valid) begin
						valid_d = 1'b1;
						first_d = next_first;
						last_d  = next_last;
						kind_d  = next_kind;
						flags_d = next_flags;
					end
				end else begin
					if (!prev_valid && valid_q) begin
						valid_d = 1'b0;
						first_d = prev_first;
						last_d  = prev_last;
						kind_d  = prev_kind;
						flags_d = prev_flags;
					end
				end
			end
			tait_pkg::OP_INSERT: begin
				if (!ahead) begin
					if (prev_ahead) begin
						valid_d = 1'b1;
						first_d = ins_first;
						last_d  = ins_last;
						kind_d  = ins_kind;
						flags_d = ins_flags;
					end else begin
						valid_d = prev_valid;
						first_d = prev_first;
						last_d  = prev_last;
						kind_d  = prev_kind;
						flags_d = prev_flags;
					end
				end
			end
			tait_pkg::OP_REMARK: begin
				if (hit) begin
					kind_d  = tait_pkg::KIND_UNEXPLORED;
					flags_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			dead_q   <= 1'b0;
			lefte_q  <= 1'b0;
			righte_q <= 1'b0;
			split_q  <= 1'b0;
		end else begin
			valid_q  <= valid_d;
			dead_q   <= dead_d;
			lefte_q  <= lefte_d;
			righte_q <= righte_d;
			split_q  <= split_d;
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_d;
		last_q  <= last_d;
		kind_q  <= kind_d;
		flags_q <= flags_d;
	end

	assign valid = valid_q;
	assign first = first_q;
	assign last  = last_q;
	assign kind  = kind_q;
	assign flags = flags_q;

endmodule

### hdl/typed_address_interval_table.sv
// find and re-mark run find, read, response (find, response on a miss), read runs read,
// response (response only out of range), mark runs scan, decide, trim, odd-even compaction
// when blocks lie wholly inside the range, an extra insert if it splits one block, insert,
// count, read, response; reversed range goes straight to response, refused mark after decide
// one request is in work at a time: the next is taken in idle after its result is loaded,
// even while it waits for m_tready; reset empties the table at once (cell valid bits clear)
module typed_address_interval_table #(
	parameter int MAX_BLOCKS = 256,
	parameter int ADDR_BITS  = 64,
	parameter int FLAG_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// range_start, range_end, block_kind_in, block_flags_in, entry_index, zero fill
	input  logic [159:0] s_tdata,
	// action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit_index, hit_start, hit_end, hit_kind, hit_flags, entry_total, zero fill
	output logic [167:0] m_tdata,
	// found, table_full
	output logic [1:0]   m_tuser
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int AB = ADDR_BITS;
	localparam int FB = FLAG_BITS;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b00000000001,
		ST_SCAN    = 11'b00000000010,
		ST_DECIDE  = 11'b00000000100,
		ST_TRIM    = 11'b00000001000,
		ST_COMPACT = 11'b00000010000,
		ST_INS_REM = 11'b00000100000,
		ST_INS_NEW = 11'b00001000000,
		ST_COUNT   = 11'b00010000000,
		ST_FIND    = 11'b00100000000,
		ST_READ    = 11'b01000000000,
		ST_RESP    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [1:0]    act_q;
	logic [AB-1:0] s_q, e_q, rem_last_q;
	logic [1:0]    kind_q;
	logic [FB-1:0] flags_q, rem_flags_q;
	logic [CW-1:0] count_q, cnt_q;
	logic [IW-1:0] rd_idx_q;
	logic          any_dead_q, split_q;
	logic          res_found_q, res_full_q;
	logic [IW-1:0] res_index_q;
	logic [AB-1:0] res_first_q, res_last_q;
	logic [1:0]    res_kind_q;
	logic [FB-1:0] res_flags_q;
	logic          out_valid_q;
	logic [167:0]  out_data_q;
	logic [1:0]    out_user_q;

	tait_pkg::cell_cmd_t  cmd;
	logic [AB-1:0]        ins_first, ins_last;
	logic [1:0]           ins_kind;
	logic [FB-1:0]        ins_flags;

	logic [MAX_BLOCKS-1:0] c_valid;
	logic [AB-1:0]         c_first [MAX_BLOCKS];
	logic [AB-1:0]         c_last  [MAX_BLOCKS];
	logic [1:0]            c_kind  [MAX_BLOCKS];
	logic [FB-1:0]         c_flags [MAX_BLOCKS];
	tait_pkg::cell_stat_t  c_stat  [MAX_BLOCKS];

	logic [MAX_BLOCKS-1:0] dead_vec, split_vec, hit_vec, took_vec, bnd_vec, ahead_vec;
	logic [AB-1:0]         split_last;
	logic [FB-1:0]         split_flags;
	logic                  any_dead, split_any, any_hit, is_full;
	logic [CW-1:0]         count_calc;

	logic [AB-1:0] in_s, in_e;
	logic [1:0]    in_kind;

	function automatic logic [IW-1:0] encode(input logic [MAX_BLOCKS-1:0] v);
		logic [IW-1:0] r;
		r = '0;
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (v[i]) r = r | IW'(i);
		return r;
	endfunction

	// cell row
	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		logic          pv, pb, nv;
		logic [AB-1:0] pf, pl, nf, nl;
		logic [1:0]    pk, nk;
		logic [FB-1:0] pfl, nfl;
		if (i == 0) begin : g_head
			// treated as a filled slot ahead of the row
			assign pv  = 1'b1;
			assign pb  = 1'b1;
			assign pf  = '0;
			assign pl  = '0;
			assign pk  = '0;
			assign pfl = '0;
		end else begin : g_mid
			assign pv  = c_valid[i-1];
			assign pb  = ahead_vec[i-1];
			assign pf  = c_first[i-1];
			assign pl  = c_last[i-1];
			assign pk  = c_kind[i-1];
			assign pfl = c_flags[i-1];
		end
		if (i == MAX_BLOCKS - 1) begin : g_tail
			assign nv  = 1'b0;
			assign nf  = '0;
			assign nl  = '0;
			assign nk  = '0;
			assign nfl = '0;
		end else begin : g_body
			assign nv  = c_valid[i+1];
			assign nf  = c_first[i+1];
			assign nl  = c_last[i+1];
			assign nk  = c_kind[i+1];
			assign nfl = c_flags[i+1];
		end
		tait_cell #(.IDX(i), .AB(AB), .FB(FB)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.s           (s_q),
			.e           (e_q),
			.ins_first   (ins_first),
			.ins_last    (ins_last),
			.ins_kind    (ins_kind),
			.ins_flags   (ins_flags),
			.prev_valid  (pv),
			.prev_ahead  (pb),
			.prev_first  (pf),
			.prev_last   (pl),
			.prev_kind   (pk),
			.prev_flags  (pfl),
			.next_valid  (nv),
			.next_first  (nf),
			.next_last   (nl),
			.next_kind   (nk),
			.next_flags  (nfl),
			.valid       (c_valid[i]),
			.first       (c_first[i]),
			.last        (c_last[i]),
			.kind        (c_kind[i]),
			.flags       (c_flags[i]),
			.stat        (c_stat[i])
		);
	end

	always_comb begin
		split_last  = '0;
		split_flags = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			dead_vec[i]  = c_stat[i].dead;
			split_vec[i] = c_stat[i].split;
			hit_vec[i]   = c_stat[i].hit;
			took_vec[i]  = c_stat[i].took_new;
			ahead_vec[i] = c_stat[i].ahead;
			if (c_stat[i].split) begin
				split_last  = split_last | c_last[i];
				split_flags = split_flags | c_flags[i];
			end
			if (i == MAX_BLOCKS - 1) bnd_vec[i] = c_valid[i];
			else bnd_vec[i] = c_valid[i] & ~c_valid[(i + 1) % MAX_BLOCKS];
		end
		any_dead   = |dead_vec;
		split_any  = |split_vec;
		any_hit    = |hit_vec;
		// filled slots form a prefix, so the top boundary gives the count
		count_calc = (|c_valid) ? CW'(encode(bnd_vec)) + CW'(1) : '0;
		is_full    = ({1'b0, count_q} + (CW+1)'(1) + (CW+1)'(split_any))
			> (CW+1)'(MAX_BLOCKS);
	end

	always_comb begin
		cmd.op    = tait_pkg::OP_HOLD;
		ins_first = s_q;
		ins_last  = e_q;
		ins_kind  = kind_q;
		ins_flags = flags_q;
		unique case (state_q)
			ST_SCAN:    cmd.op = tait_pkg::OP_SCAN;
			ST_TRIM:    cmd.op = tait_pkg::OP_TRIM;
			ST_COMPACT: cmd.op = cnt_q[0] ? tait_pkg::OP_SWAP_ODD : tait_pkg::OP_SWAP_EVEN;
			ST_INS_REM: begin
				cmd.op    = tait_pkg::OP_INSERT;
				ins_first = e_q + AB'(1);
				ins_last  = rem_last_q;
				ins_kind  = tait_pkg::KIND_UNEXPLORED;
				ins_flags = rem_flags_q;
			end
			ST_INS_NEW: cmd.op = tait_pkg::OP_INSERT;
			ST_FIND: begin
				if (act_q == tait_pkg::ACT_REMARK && any_hit) cmd.op = tait_pkg::OP_REMARK;
			end
			default: cmd.op = tait_pkg::OP_HOLD;
		endcase
	end

	assign in_s    = s_tdata[AB-1:0];
	assign in_e    = s_tdata[64 +: AB];
	assign in_kind = (s_tdata[129:128] == tait_pkg::KIND_INVALID) ?
		tait_pkg::KIND_UNEXPLORED : s_tdata[129:128];

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cnt_q       <= '0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
			any_dead_q  <= 1'b0;
			split_q     <= 1'b0;
			act_q       <= tait_pkg::ACT_MARK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_RESP) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						act_q       <= s_tuser;
						s_q         <= in_s;
						e_q         <= in_e;
						kind_q      <= in_kind;
						flags_q     <= FB'(s_tdata[145:130]);
						res_found_q <= 1'b0;
						res_full_q  <= 1'b0;
						unique case (s_tuser) inside
							tait_pkg::ACT_MARK:
								state_q <= (in_e < in_s) ? ST_RESP : ST_SCAN;
							tait_pkg::ACT_REMARK, tait_pkg::ACT_FIND:
								state_q <= ST_FIND;
							tait_pkg::ACT_READ: begin
								if (32'(s_tdata[153:146]) < 32'(count_q)) begin
									rd_idx_q <= IW'(s_tdata[153:146]);
									state_q  <= ST_READ;
								end else begin
									state_q <= ST_RESP;
								end
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_SCAN: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					any_dead_q  <= any_dead;
					split_q     <= split_any;
					rem_last_q  <= split_last;
					rem_flags_q <= split_flags;
					// only a mark that removes nothing can grow past capacity
					if (!any_dead && is_full) begin
						res_full_q <= 1'b1;
						state_q    <= ST_RESP;
					end else begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					cnt_q <= '0;
					if (any_dead_q) state_q <= ST_COMPACT;
					else if (split_q) state_q <= ST_INS_REM;
					else state_q <= ST_INS_NEW;
				end
				ST_COMPACT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MAX_BLOCKS - 1))
						state_q <= split_q ? ST_INS_REM : ST_INS_NEW;
				end
				ST_INS_REM: state_q <= ST_INS_NEW;
				ST_INS_NEW: begin
					rd_idx_q <= encode(took_vec);
					state_q  <= ST_COUNT;
				end
				ST_COUNT: begin
					count_q <= count_calc;
					state_q <= ST_READ;
				end
				ST_FIND: begin
					if (any_hit) begin
						rd_idx_q <= encode(hit_vec);
						state_q  <= ST_READ;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_READ: begin
					res_found_q <= 1'b1;
					res_index_q <= rd_idx_q;
					res_first_q <= c_first[rd_idx_q];
					res_last_q  <= c_last[rd_idx_q];
					res_kind_q  <= c_kind[rd_idx_q];
					res_flags_q <= c_flags[rd_idx_q];
					state_q     <= ST_RESP;
				end
				ST_RESP: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_user_q  <= {res_full_q, res_found_q};
						if (res_found_q)
							out_data_q <= {5'd0, 9'(count_q), 16'(res_flags_q), res_kind_q,
								64'(res_last_q), 64'(res_first_q), 8'(res_index_q)};
						else
							out_data_q <= {5'd0, 9'(count_q), 154'd0};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

### hdl/tait_checker.sv
// port-level checks of the typed address interval table, bound to the top level
`include "typed_address_interval_table_assert.svh"

module tait_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [159:0] s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [167:0] m_tdata,
	input logic [1:0]   m_tuser
);

	// a refused mark never reports a block
	`TAIT_CHECK(a_full_not_found, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "found and full together")

	// no block found means all block fields read zero
	`TAIT_CHECK(a_miss_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata[153:0] == 154'd0), "miss with data")

	// a stalled result keeps its data
	`TAIT_CHECK(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed under stall")

	`TAIT_CHECK_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result during reset")

endmodule

bind typed_address_interval_table tait_checker u_tait_checker (.*);

### tb/typed_address_interval_table_tb.sv
// testbench for the typed address interval table: stream driver, monitor and table predictor
`timescale 1ns / 100ps

module typed_address_interval_table_tb;

	localparam int TABLE_DEPTH = 256;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]  action;
		logic [63:0] first_addr;
		logic [63:0] last_addr;
		logic [1:0]  kind;
		logic [15:0] flags;
		logic [7:0]  index;
	} request_t;

	typedef struct {
		logic        found;
		logic        full;
		logic [7:0]  index;
		logic [63:0] first_addr;
		logic [63:0] last_addr;
		logic [1:0]  kind;
		logic [15:0] flags;
		logic [8:0]  total;
	} answer_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b1;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [167:0] m_tdata;
	logic [1:0]   m_tuser;

	typed_address_interval_table uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow table
	logic [63:0] blk_first [TABLE_DEPTH];
	logic [63:0] blk_last [TABLE_DEPTH];
	logic [1:0]  blk_kind [TABLE_DEPTH];
	logic [15:0] blk_flags [TABLE_DEPTH];
	int          blk_count = 0;
	logic [63:0] tmp_first [TABLE_DEPTH];
	logic [63:0] tmp_last [TABLE_DEPTH];
	logic [1:0]  tmp_kind [TABLE_DEPTH];
	logic [15:0] tmp_flags [TABLE_DEPTH];

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	request_t in_flight;
	int       sender_idle_pct = 0;
	int       receiver_stall_pct = 0;
	int       mismatches = 0;
	int       cycles = 0;
	logic     hold_req = 1'b0;
	logic     hold_started = 1'b0;
	int       hold_left = 0;

	function automatic answer_t answer_for(logic found, logic full, int pos);
		answer_t a;
		a = '{default: '0};
		a.found = found;
		a.full = full;
		if (found) begin
			a.index = pos[7:0];
			a.first_addr = blk_first[pos];
			a.last_addr = blk_last[pos];
			a.kind = blk_kind[pos];
			a.flags = blk_flags[pos];
		end
		a.total = blk_count[8:0];
		return a;
	endfunction

	function automatic void keep_block(inout int n, input logic [63:0] f, input logic [63:0] l,
			input logic [1:0] k, input logic [15:0] fl);
		tmp_first[n] = f;
		tmp_last[n] = l;
		tmp_kind[n] = k;
		tmp_flags[n] = fl;
		n++;
	endfunction

	function automatic answer_t apply_request(request_t r);
		int lo, hi, n, pos, total;
		logic left, right;
		logic [1:0] kind;
		lo = 0;
		hi = 0;
		n = 0;
		pos = blk_count;
		left = 1'b0;
		right = 1'b0;
		kind = (r.kind == tait_pkg::KIND_INVALID) ? tait_pkg::KIND_UNEXPLORED : r.kind;
		case (r.action) inside
			tait_pkg::ACT_MARK: begin
				if (r.last_addr < r.first_addr)
					return answer_for(1'b0, 1'b0, 0);
				for (int i = 0; i < blk_count; i++) begin
					if (blk_last[i] < r.first_addr) lo = i + 1;
					if (blk_first[i] <= r.last_addr) hi = i + 1;
				end
				if (hi > lo) begin
					left = blk_first[lo] < r.first_addr;
					right = blk_last[hi - 1] > r.last_addr;
				end else begin
					hi = lo;
				end
				total = blk_count - (hi - lo) + 1 + int'(left) + int'(right);
				if (total > TABLE_DEPTH)
					return answer_for(1'b0, 1'b1, 0);
				for (int i = 0; i < lo; i++)
					keep_block(n, blk_first[i], blk_last[i], blk_kind[i], blk_flags[i]);
				// edge pieces outside the range fall back to unexplored, flags kept
				if (left)
					keep_block(n, blk_first[lo], r.first_addr - 64'd1,
						tait_pkg::KIND_UNEXPLORED, blk_flags[lo]);
				pos = n;
				keep_block(n, r.first_addr, r.last_addr, kind, r.flags);
				if (right)
					keep_block(n, r.last_addr + 64'd1, blk_last[hi - 1],
						tait_pkg::KIND_UNEXPLORED, blk_flags[hi - 1]);
				for (int i = hi; i < blk_count; i++)
					keep_block(n, blk_first[i], blk_last[i], blk_kind[i], blk_flags[i]);
				for (int i = 0; i < n; i++) begin
					blk_first[i] = tmp_first[i];
					blk_last[i] = tmp_last[i];
					blk_kind[i] = tmp_kind[i];
					blk_flags[i] = tmp_flags[i];
				end
				blk_count = n;
				return answer_for(1'b1, 1'b0, pos);
			end
			tait_pkg::ACT_REMARK, tait_pkg::ACT_FIND: begin
				for (int i = blk_count - 1; i >= 0; i--)
					if (blk_first[i] <= r.first_addr && r.first_addr <= blk_last[i]) pos = i;
				if (pos >= blk_count)
					return answer_for(1'b0, 1'b0, 0);
				if (r.action == tait_pkg::ACT_REMARK) begin
					blk_kind[pos] = tait_pkg::KIND_UNEXPLORED;
					blk_flags[pos] = '0;
				end
				return answer_for(1'b1, 1'b0, pos);
			end
			default: begin
				if (r.index < blk_count)
					return answer_for(1'b1, 1'b0, r.index);
				return answer_for(1'b0, 1'b0, 0);
			end
		endcase
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_answers.push_back(apply_request(in_flight));
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_flight = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, in_flight.index, in_flight.flags, in_flight.kind,
						in_flight.last_addr, in_flight.first_addr};
					s_tuser <= in_flight.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_req && !hold_started) begin
			hold_started <= 1'b1;
			hold_left <= 600;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %h, got %h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// receiver
	always @(posedge clk) begin
		answer_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_answers.size() == 0) begin
					$error("result with no request pending");
					mismatches++;
				end else begin
					e = expected_answers.pop_front();
					check_field("found", e.found, m_tuser[0]);
					check_field("table_full", e.full, m_tuser[1]);
					check_field("hit_index", e.index, m_tdata[7:0]);
					check_field("hit_start", e.first_addr, m_tdata[71:8]);
					check_field("hit_end", e.last_addr, m_tdata[135:72]);
					check_field("hit_kind", e.kind, m_tdata[137:136]);
					check_field("hit_flags", e.flags, m_tdata[153:138]);
					check_field("entry_total", e.total, m_tdata[162:154]);
				end
			end
			m_tready <= (hold_left > 1) ? 1'b0 : ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("typed_address_interval_table verification failed");
			$finish;
		end
	end

	task automatic queue_request(logic [1:0] act, logic [63:0] f, logic [63:0] l,
			logic [1:0] k, logic [15:0] fl, logic [7:0] idx);
		request_t r;
		r.action = act;
		r.first_addr = f;
		r.last_addr = l;
		r.kind = k;
		r.flags = fl;
		r.index = idx;
		pending_requests.push_back(r);
	endtask

	function automatic logic [63:0] some_address(int wide_pct);
		if ($urandom_range(99) < wide_pct)
			return {$urandom, $urandom};
		return 64'($urandom_range(0, 4095));
	endfunction

	task automatic queue_random_request();
		int pick;
		logic [63:0] f, l;
		pick = $urandom_range(99);
		f = some_address(5);
		if (pick < 65) begin
			// mostly short ranges in a small window so the table fills up
			if ($urandom_range(99) < 4)
				l = {$urandom, $urandom};
			else if ($urandom_range(99) < 3)
				l = f - 64'd1;
			else
				l = f + 64'($urandom_range(0, 15));
			if (l < f && $urandom_range(99) < 50) l = f;
			queue_request(tait_pkg::ACT_MARK, f, l, 2'($urandom_range(0, 3)), 16'($urandom),
				8'($urandom));
		end else if (pick < 75) begin
			queue_request(tait_pkg::ACT_REMARK, f, {$urandom, $urandom}, 2'($urandom),
				16'($urandom), 8'($urandom));
		end else if (pick < 88) begin
			queue_request(tait_pkg::ACT_FIND, f, {$urandom, $urandom}, 2'($urandom),
				16'($urandom), 8'($urandom));
		end else begin
			queue_request(tait_pkg::ACT_READ, {$urandom, $urandom}, {$urandom, $urandom},
				2'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || s_tvalid || expected_answers.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		queue_request(tait_pkg::ACT_READ, 64'd0, 64'd0, 2'd0, 16'd0, 8'd0);
		queue_request(tait_pkg::ACT_FIND, 64'd5, 64'd0, 2'd0, 16'd0, 8'd0);
		queue_request(tait_pkg::ACT_REMARK, 64'd5, 64'd0, 2'd0, 16'd0, 8'd0);
		queue_request(tait_pkg::ACT_MARK, 64'd10, 64'd9, 2'd1, 16'hffff, 8'd0);
		queue_request(tait_pkg::ACT_MARK, 64'd0, '1, 2'd1, 16'hffff, 8'hff);
		queue_request(tait_pkg::ACT_MARK, 64'd100, 64'd200, tait_pkg::KIND_INVALID, 16'h0000,
			8'd0);
		queue_request(tait_pkg::ACT_FIND, 64'd150, 64'd0, 2'd0, 16'd0, 8'd0);
		queue_request(tait_pkg::ACT_REMARK, 64'd150, 64'd0, 2'd0, 16'd0, 8'd0);
		queue_request(tait_pkg::ACT_FIND, 64'd50, 64'd0, 2'd0, 16'd0, 8'd0);
		queue_request(tait_pkg::ACT_FIND, '1, 64'd0, 2'd0, 16'd0, 8'd0);
		queue_request(tait_pkg::ACT_READ, 64'd0, 64'd0, 2'd0, 16'd0, 8'd0);
		queue_request(tait_pkg::ACT_READ, 64'd0, 64'd0, 2'd0, 16'd0, 8'd2);
		queue_request(tait_pkg::ACT_READ, 64'd0, 64'd0, 2'd0, 16'd0, 8'd3);
		queue_request(tait_pkg::ACT_READ, 64'd0, 64'd0, 2'd0, 16'd0, 8'hff);
		queue_request(tait_pkg::ACT_MARK, 64'd0, 64'd0, 2'd2, 16'h5a5a, 8'd0);
		queue_request(tait_pkg::ACT_MARK, '1, '1, 2'd2, 16'ha5a5, 8'd0);
		queue_request(tait_pkg::ACT_MARK, 64'd120, 64'd130, 2'd1, 16'h0001, 8'd0);
		queue_request(tait_pkg::ACT_MARK, 64'd140, 64'd160, 2'd2, 16'h8000, 8'd0);
		// swallows several blocks whole
		queue_request(tait_pkg::ACT_MARK, 64'd50, 64'd1000, 2'd2, 16'h1234, 8'd0);
		queue_request(tait_pkg::ACT_READ, 64'd0, 64'd0, 2'd0, 16'd0, 8'd1);
		queue_request(tait_pkg::ACT_FIND, 64'd1000, 64'd0, 2'd0, 16'd0, 8'd0);
		drain();

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = (ph == 1) ? 86 : (ph == 3) ? 15 : 0;
			receiver_stall_pct = (ph == 2) ? 86 : (ph == 3) ? 15 : 0;
			for (int i = 0; i < 450; i++) queue_random_request();
			if (ph == 0) hold_req <= 1'b1;
			drain();
		end

		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("typed_address_interval_table verification clean");
		else
			$display("typed_address_interval_table verification failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/tait_pkg.sv
hdl/tait_cell.sv
hdl/typed_address_interval_table.sv
hdl/tait_checker.sv
tb/typed_address_interval_table_tb.sv
